FILE: hw/rtl/wrsd_pkg.sv
package wrsd_pkg;

  localparam int RAW_W    = 16;
  localparam int SHIFT    = 5;
  localparam int SAMPLE_W = 11;
  localparam int TREND_W  = 11;
  localparam int HOLD_W   = 8;
  localparam int STILL_W  = 16;
  localparam int AXES     = 3;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  localparam int TREND_WINDOW_DEF = 10;
  localparam int BATCH_MAX_DEF    = 16;

  typedef logic signed [SAMPLE_W-1:0] smp_t;

  localparam smp_t SMP_ZERO    = '0;
  localparam smp_t UP_Y_MIN    = -11'sd200;
  localparam smp_t UP_X_MIN    = -11'sd112;
  localparam smp_t UP_X_MAX    = 11'sd112;
  localparam smp_t AWAY_Y_MIN  = -11'sd240;
  localparam smp_t AWAY_Y_MAX  = 11'sd50;
  localparam smp_t AWAY_X_MIN  = -11'sd161;
  localparam smp_t AWAY_X_MAX  = 11'sd161;

  localparam logic [TREND_W-1:0] CAMERA_THR_RST   = 11'd170;
  localparam logic [TREND_W-1:0] STILL_BELOW_RST  = 11'd25;
  localparam logic [TREND_W-1:0] MOVING_ABOVE_RST = 11'd30;
  localparam logic [HOLD_W-1:0]  UPRIGHT_HOLD_RST = 8'd5;
  localparam logic [HOLD_W-1:0]  AWAY_HOLD_RST    = 8'd4;

  typedef enum logic [2:0] {
    REG_CAMERA_THR   = 3'd0,
    REG_STILL_BELOW  = 3'd1,
    REG_MOVING_ABOVE = 3'd2,
    REG_UPRIGHT_HOLD = 3'd3,
    REG_AWAY_HOLD    = 3'd4
  } reg_idx_t;

  // Status of the batch evaluation unit towards the control logic.
  typedef struct packed {
    logic               done;
    logic [TREND_W-1:0] trend;
  } trend_rsp_t;

  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: hw/rtl/wrsd_ram.sv
module wrsd_ram import wrsd_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = addr_w(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/wrsd_trend.sv
module wrsd_trend import wrsd_pkg::*; #(
  parameter int TREND_WINDOW = TREND_WINDOW_DEF,
  localparam int AW = addr_w(TREND_WINDOW),
  localparam int LW = $clog2(TREND_WINDOW + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [LW-1:0]           len,
  output logic [AW-1:0]           rd_addr,
  input  logic [AXES*SAMPLE_W-1:0] rd_data,
  output trend_rsp_t              rsp
);

  // Sum of up to TREND_WINDOW samples, and the step counter of the divider.
  localparam int SW  = SAMPLE_W + $clog2(TREND_WINDOW);
  localparam int DCW = $clog2(SW);

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_SUM  = 5'b00010,
    T_LOAD = 5'b00100,
    T_DIV  = 5'b01000,
    T_DEV  = 5'b10000
  } tstate_t;

  typedef logic signed [SW-1:0] sum_t;

  tstate_t            st_r, st_nxt;
  logic [LW-1:0]      k_r, k_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [1:0]         ax_r, ax_nxt;
  logic [DCW-1:0]     bc_r, bc_nxt;
  logic [SW-1:0]      q_r, q_nxt;
  logic [LW:0]        rem_r, rem_nxt;
  logic               neg_r, neg_nxt;
  sum_t               sum_r [AXES];
  sum_t               sum_nxt [AXES];
  smp_t               mean_r [AXES];
  smp_t               mean_nxt [AXES];
  logic [TREND_W-1:0] best_r, best_nxt;
  logic               done_r, done_nxt;

  smp_t               rd_s [AXES];
  logic [LW:0]        rem_sh;
  logic               ge;
  logic [LW:0]        rem_step;
  logic [SW-1:0]      q_step;
  logic [TREND_W-1:0] dev_max;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rd_s[a] = rd_data[a*SAMPLE_W +: SAMPLE_W];
    end
  end

  assign rd_addr = AW'(k_r);

  // One restoring step of the shared divider.
  assign rem_sh   = {rem_r[LW-1:0], q_r[SW-1]};
  assign ge       = rem_sh >= {1'b0, len_r};
  assign rem_step = ge ? (rem_sh - {1'b0, len_r}) : rem_sh;
  assign q_step   = {q_r[SW-2:0], ge};

  always_comb begin
    logic signed [SAMPLE_W:0] d;
    logic [SAMPLE_W:0]        ad;
    dev_max = best_r;
    for (int a = 0; a < AXES; a++) begin
      d  = {rd_s[a][SAMPLE_W-1], rd_s[a]} - {mean_r[a][SAMPLE_W-1], mean_r[a]};
      ad = d[SAMPLE_W] ? (-d) : d;
      if (ad[TREND_W-1:0] > dev_max) begin
        dev_max = ad[TREND_W-1:0];
      end
    end
  end

  always_comb begin
    st_nxt   = st_r;
    k_nxt    = k_r;
    len_nxt  = len_r;
    ax_nxt   = ax_r;
    bc_nxt   = bc_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    sum_nxt  = sum_r;
    mean_nxt = mean_r;
    best_nxt = best_r;
    done_nxt = 1'b0;
    unique case (st_r)
      T_IDLE: begin
        if (start) begin
          st_nxt  = T_SUM;
          k_nxt   = '0;
          len_nxt = len;
          for (int a = 0; a < AXES; a++) begin
            sum_nxt[a] = '0;
          end
        end
      end
      T_SUM: begin
        // Read data arrives in the cycle after its address is given.
        if (k_r != '0) begin
          for (int a = 0; a < AXES; a++) begin
            sum_nxt[a] = sum_r[a] + SW'(rd_s[a]);
          end
        end
        if (k_r == len_r) begin
          st_nxt = T_LOAD;
          ax_nxt = '0;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      T_LOAD: begin
        neg_nxt = sum_r[ax_r][SW-1];
        q_nxt   = sum_r[ax_r][SW-1] ? SW'(-sum_r[ax_r]) : SW'(sum_r[ax_r]);
        rem_nxt = '0;
        bc_nxt  = '0;
        st_nxt  = T_DIV;
      end
      T_DIV: begin
        q_nxt   = q_step;
        rem_nxt = rem_step;
        if (bc_r == DCW'(SW - 1)) begin
          // The mean truncates towards zero, so the sign is put back afterwards.
          mean_nxt[ax_r] = neg_r ? smp_t'(-q_step[SAMPLE_W-1:0])
                                 : smp_t'(q_step[SAMPLE_W-1:0]);
          if (ax_r == 2'd2) begin
            st_nxt   = T_DEV;
            k_nxt    = '0;
            best_nxt = '0;
          end else begin
            ax_nxt = ax_r + 2'd1;
            st_nxt = T_LOAD;
          end
        end else begin
          bc_nxt = bc_r + 1'b1;
        end
      end
      T_DEV: begin
        if (k_r != '0) begin
          best_nxt = dev_max;
        end
        if (k_r == len_r) begin
          done_nxt = 1'b1;
          st_nxt   = T_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: begin
        st_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= T_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    k_r    <= k_nxt;
    len_r  <= len_nxt;
    ax_r   <= ax_nxt;
    bc_r   <= bc_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    sum_r  <= sum_nxt;
    mean_r <= mean_nxt;
    best_r <= best_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.trend = best_r;

endmodule

FILE: hw/rtl/wrist_raise_and_stillness_detector.sv
// Channel   Direction  Transfer when               Ports
// input     in         start high while busy low   in_action, in_sample_x/y/z, in_batch_end
// result    out        out_valid high (one cycle)  out_raise_flag ... out_trend_valid
// config    in/out     psel, penable, pwrite high  paddr, pwdata, prdata, pready
//
// A clear action or a sample that does not close an evaluated batch puts its result on the
// ports once the item has passed the input registers and the execute state, whose outcome is
// registered. A sample that closes a batch of L = min(n, TREND_WINDOW) samples puts it there
// once the batch unit has summed the L stored samples, formed the three means with the
// bit-serial divider over the batch sum (15 bits wide for a ten-sample window) and found the
// largest deviation from them; the wait is set by the single read port of the sample store and
// that divider. Reset is synchronous and active low and needs no clearing pass. The result is
// shown for one cycle and cannot be held off; a new item is taken in the cycle it is shown.
module wrist_raise_and_stillness_detector import wrsd_pkg::*; #(
  parameter int TREND_WINDOW = TREND_WINDOW_DEF,
  parameter int BATCH_MAX    = BATCH_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_action,
  input  logic signed [RAW_W-1:0] in_sample_x,
  input  logic signed [RAW_W-1:0] in_sample_y,
  input  logic signed [RAW_W-1:0] in_sample_z,
  input  logic                in_batch_end,
  output logic                out_valid,
  output logic                out_raise_flag,
  output logic                out_camera_flag,
  output logic [STILL_W-1:0]  out_still_count,
  output logic [TREND_W-1:0]  out_trend,
  output logic                out_trend_valid,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int AW = addr_w(TREND_WINDOW);
  localparam int LW = $clog2(TREND_WINDOW + 1);
  localparam int CW = $clog2(BATCH_MAX + 2);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_TREND = 3'b100
  } state_t;

  state_t             st_r, st_nxt;
  logic               action_r, action_nxt;
  smp_t               x_r, x_nxt;
  smp_t               y_r, y_nxt;
  smp_t               z_r, z_nxt;
  logic               be_r, be_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [HOLD_W-1:0]  up_run_r, up_run_nxt;
  logic [HOLD_W-1:0]  away_run_r, away_run_nxt;
  logic               arm_r, arm_nxt;
  logic               pend_r, pend_nxt;
  logic               cam_r, cam_nxt;
  logic [STILL_W-1:0] still_r, still_nxt;
  logic [TREND_W-1:0] last_trend_r, last_trend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_tv_r, out_tv_nxt;

  logic [TREND_W-1:0] camera_thr_r;
  logic [TREND_W-1:0] still_below_r;
  logic [TREND_W-1:0] moving_above_r;
  logic [HOLD_W-1:0]  upright_hold_r;
  logic [HOLD_W-1:0]  away_hold_r;

  logic               accept;
  logic               up;
  logic               away;
  logic [HOLD_W-1:0]  up_run_new;
  logic [HOLD_W-1:0]  away_run_new;
  logic [CW-1:0]      count_inc;
  logic               wr_en;
  logic               trend_start;
  logic [LW-1:0]      trend_len;
  logic [AW-1:0]      rd_addr;
  logic [AXES*SAMPLE_W-1:0] rd_data;
  trend_rsp_t         rsp;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign accept = start && !busy;
  assign busy   = (st_r != S_IDLE);

  // Wrist-raise detector conditions on the shifted sample.
  assign up   = (y_r > UP_Y_MIN) && (y_r <= SMP_ZERO) && (x_r >= UP_X_MIN) &&
                (x_r <= UP_X_MAX) && (z_r > SMP_ZERO);
  assign away = (z_r < SMP_ZERO) || (y_r < AWAY_Y_MIN) || (y_r > AWAY_Y_MAX) ||
                (x_r < AWAY_X_MIN) || (x_r > AWAY_X_MAX);

  assign up_run_new   = !up ? '0 : ((up_run_r == '1) ? up_run_r : up_run_r + 1'b1);
  assign away_run_new = (up || !away) ? '0
                      : ((away_run_r == '1) ? away_run_r : away_run_r + 1'b1);

  // The sample counter stops one past the longest batch that is still evaluated.
  assign count_inc = (32'(count_r) < BATCH_MAX + 1) ? count_r + 1'b1 : count_r;
  assign wr_en     = (st_r == S_EXEC) && !action_r && (32'(count_r) < TREND_WINDOW);
  assign trend_start = (st_r == S_EXEC) && !action_r && be_r &&
                       (32'(count_inc) <= BATCH_MAX);
  assign trend_len = (32'(count_inc) < TREND_WINDOW) ? LW'(count_inc) : LW'(TREND_WINDOW);

  always_comb begin
    st_nxt         = st_r;
    action_nxt     = action_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    be_nxt         = be_r;
    count_nxt      = count_r;
    up_run_nxt     = up_run_r;
    away_run_nxt   = away_run_r;
    arm_nxt        = arm_r;
    pend_nxt       = pend_r;
    cam_nxt        = cam_r;
    still_nxt      = still_r;
    last_trend_nxt = last_trend_r;
    out_valid_nxt  = 1'b0;
    out_tv_nxt     = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          action_nxt = in_action;
          x_nxt      = smp_t'(in_sample_x >>> SHIFT);
          y_nxt      = smp_t'(in_sample_y >>> SHIFT);
          z_nxt      = smp_t'(in_sample_z >>> SHIFT);
          be_nxt     = in_batch_end;
          st_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (action_r) begin
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end else begin
          // A pending gesture freezes the detector.
          if (!pend_r) begin
            up_run_nxt   = up_run_new;
            away_run_nxt = away_run_new;
            if (up_run_new >= upright_hold_r) begin
              if (!arm_r) begin
                arm_nxt  = 1'b1;
                pend_nxt = 1'b1;
              end
            end else if (away_run_new >= away_hold_r) begin
              arm_nxt = 1'b0;
            end
          end
          if (be_r) begin
            count_nxt = '0;
          end else begin
            count_nxt = count_inc;
          end
          if (trend_start) begin
            st_nxt = S_TREND;
          end else begin
            out_valid_nxt = 1'b1;
            st_nxt        = S_IDLE;
          end
        end
      end
      S_TREND: begin
        if (rsp.done) begin
          if (rsp.trend < still_below_r) begin
            if (still_r != '1) begin
              still_nxt = still_r + 1'b1;
            end
          end else if (rsp.trend > moving_above_r) begin
            still_nxt = '0;
          end
          if (rsp.trend > camera_thr_r) begin
            cam_nxt = 1'b1;
          end
          last_trend_nxt = rsp.trend;
          out_valid_nxt  = 1'b1;
          out_tv_nxt     = 1'b1;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      count_r      <= '0;
      up_run_r     <= '0;
      away_run_r   <= '0;
      arm_r        <= 1'b0;
      pend_r       <= 1'b0;
      cam_r        <= 1'b0;
      still_r      <= '0;
      last_trend_r <= '0;
      out_valid_r  <= 1'b0;
      out_tv_r     <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      count_r      <= count_nxt;
      up_run_r     <= up_run_nxt;
      away_run_r   <= away_run_nxt;
      arm_r        <= arm_nxt;
      pend_r       <= pend_nxt;
      cam_r        <= cam_nxt;
      still_r      <= still_nxt;
      last_trend_r <= last_trend_nxt;
      out_valid_r  <= out_valid_nxt;
      out_tv_r     <= out_tv_nxt;
    end
    action_r <= action_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    z_r      <= z_nxt;
    be_r     <= be_nxt;
  end

  // Configuration registers; the low address bits are not decoded.
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camera_thr_r   <= CAMERA_THR_RST;
      still_below_r  <= STILL_BELOW_RST;
      moving_above_r <= MOVING_ABOVE_RST;
      upright_hold_r <= UPRIGHT_HOLD_RST;
      away_hold_r    <= AWAY_HOLD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CAMERA_THR:   camera_thr_r   <= pwdata[TREND_W-1:0];
        REG_STILL_BELOW:  still_below_r  <= pwdata[TREND_W-1:0];
        REG_MOVING_ABOVE: moving_above_r <= pwdata[TREND_W-1:0];
        REG_UPRIGHT_HOLD: upright_hold_r <= pwdata[HOLD_W-1:0];
        REG_AWAY_HOLD:    away_hold_r    <= pwdata[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CAMERA_THR:   prdata = PDATA_W'(camera_thr_r);
      REG_STILL_BELOW:  prdata = PDATA_W'(still_below_r);
      REG_MOVING_ABOVE: prdata = PDATA_W'(moving_above_r);
      REG_UPRIGHT_HOLD: prdata = PDATA_W'(upright_hold_r);
      REG_AWAY_HOLD:    prdata = PDATA_W'(away_hold_r);
      default:          prdata = '0;
    endcase
  end

  wrsd_ram #(
    .WIDTH(AXES * SAMPLE_W),
    .DEPTH(TREND_WINDOW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(AW'(count_r)),
    .wr_data({z_r, y_r, x_r}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  wrsd_trend #(
    .TREND_WINDOW(TREND_WINDOW)
  ) u_trend (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (trend_start),
    .len    (trend_len),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .rsp    (rsp)
  );

  assign out_valid       = out_valid_r;
  assign out_raise_flag  = pend_r;
  assign out_camera_flag = cam_r;
  assign out_still_count = still_r;
  assign out_trend       = last_trend_r;
  assign out_trend_valid = out_tv_r;

  a_no_back_to_back_results: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  a_accept_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not make the block busy");

  a_done_only_in_trend: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (st_r == S_TREND))
    else $error("batch evaluation finished outside the trend wait");

  a_camera_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    cam_r |=> cam_r)
    else $error("camera flag dropped without reset");

  a_trend_valid_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_trend_valid |-> (out_valid && ($past(st_r) == S_TREND)))
    else $error("trend marked valid without a finished batch evaluation");

endmodule
